### sv/mks_pkg.sv
package mks_pkg;

  localparam logic [4:0] NoKey = 5'd27;
  localparam logic [3:0] AllRows = 4'hF;
  localparam logic [7:0] DebounceReset = 8'd5;
  localparam int unsigned InDataW = 8;
  localparam int unsigned OutDataW = 16;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_DEBOUNCE = 3'd1,
    PH_SAMPLE   = 3'd2,
    PH_WAIT     = 3'd3
  } phase_e;

  typedef struct packed {
    logic [4:0] key_code;
    logic       key_valid;
    logic [3:0] row_drive;
  } result_t;

  function automatic logic [4:0] key_lookup(input logic [1:0] row, input logic [1:0] col);
    logic [4:0] code;
    case ({row, col})
      4'h0: code = 5'd1;
      4'h1: code = 5'd5;
      4'h2: code = 5'd9;
      4'h3: code = 5'd13;
      4'h4: code = 5'd2;
      4'h5: code = 5'd6;
      4'h6: code = 5'd0;
      4'h7: code = 5'd14;
      4'h8: code = 5'd3;
      4'h9: code = 5'd7;
      4'hA: code = 5'd11;
      4'hB: code = 5'd15;
      4'hC: code = 5'd4;
      4'hD: code = 5'd8;
      4'hE: code = 5'd12;
      4'hF: code = 5'd16;
      default: code = NoKey;
    endcase
    return code;
  endfunction

endpackage

### sv/mks_core.sv
module mks_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  logic [3:0]         cols_i,
  input  logic               tick_i,
  input  logic [7:0]         debounce_ticks_i,
  output mks_pkg::result_t   res_o
);

  mks_pkg::phase_e phase_q, phase_d;
  logic [1:0] row_q, row_d;
  logic [7:0] count_q, count_d;
  logic [4:0] code_q, code_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= mks_pkg::PH_IDLE;
      row_q   <= 2'd0;
      count_q <= 8'd0;
      code_q  <= mks_pkg::NoKey;
    end else if (step_i) begin
      phase_q <= phase_d;
      row_q   <= row_d;
      count_q <= count_d;
      code_q  <= code_d;
    end
  end

  always_comb begin
    logic       advance;
    logic       single;
    logic [1:0] col;
    phase_d = phase_q;
    row_d   = row_q;
    count_d = count_q;
    code_d  = code_q;
    advance = 1'b0;
    single  = 1'b1;
    col     = 2'd0;
    res_o.key_valid = 1'b0;
    res_o.key_code  = 5'd0;

    case (cols_i)
      4'h1: col = 2'd0;
      4'h2: col = 2'd1;
      4'h4: col = 2'd2;
      4'h8: col = 2'd3;
      default: single = 1'b0;
    endcase

    case (phase_q)
      mks_pkg::PH_DEBOUNCE: begin
        if (count_q >= debounce_ticks_i) begin
          if (cols_i == 4'h0) begin
            phase_d = mks_pkg::PH_IDLE;
          end else begin
            phase_d = mks_pkg::PH_SAMPLE;
            row_d   = 2'd0;
            code_d  = mks_pkg::NoKey;
          end
        end else if (tick_i) begin
          count_d = count_q + 8'd1;
        end
      end
      mks_pkg::PH_SAMPLE: begin
        if (single) begin
          code_d = mks_pkg::key_lookup(row_q, col);
        end
        if (cols_i == 4'h0) begin
          advance = 1'b1;
        end else begin
          phase_d = mks_pkg::PH_WAIT;
        end
      end
      mks_pkg::PH_WAIT: begin
        if (cols_i == 4'h0) begin
          advance = 1'b1;
        end
      end
      default: begin
        phase_d = mks_pkg::PH_IDLE;
        if (cols_i != 4'h0) begin
          phase_d = mks_pkg::PH_DEBOUNCE;
          count_d = 8'd0;
        end
      end
    endcase

    if (advance) begin
      if (row_q != 2'd3) begin
        row_d   = row_q + 2'd1;
        phase_d = mks_pkg::PH_SAMPLE;
      end else begin
        res_o.key_valid = 1'b1;
        res_o.key_code  = code_d;
        phase_d = mks_pkg::PH_IDLE;
        row_d   = 2'd0;
      end
    end

    if (phase_d == mks_pkg::PH_SAMPLE || phase_d == mks_pkg::PH_WAIT) begin
      res_o.row_drive = 4'b0001 << row_d;
    end else begin
      res_o.row_drive = mks_pkg::AllRows;
    end
  end

endmodule

### sv/matrix_keypad_scanner_top.sv
// Each accepted request updates the result register that drives m_axis_tdata.
// Throughput: one request per cycle unless a pending result is stalled by
// m_axis_tready; the scan state updates in a single pass between the input
// handshake and the result register. Reset: asynchronous, active low; no
// result pending, debounce_ticks returns to 5; the result register is not reset.
module matrix_keypad_scanner_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [3:0] column_levels, [4] ms_tick, [7:5] zero
  input  logic [mks_pkg::InDataW-1:0]   s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [3:0] row_drive, [4] key_valid, [9:5] key_code, [15:10] zero
  output logic [mks_pkg::OutDataW-1:0]  m_axis_tdata,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [7:0]                    cfg_data_i
);

  logic [7:0] debounce_q;
  logic       out_valid_q;
  mks_pkg::result_t res_d, res_q;
  logic       step;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign step          = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= mks_pkg::DebounceReset;
    end else if (cfg_valid_i) begin
      debounce_q <= cfg_data_i;
    end
  end

  mks_core u_core (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .step_i           (step),
    .cols_i           (s_axis_tdata[3:0]),
    .tick_i           (s_axis_tdata[4]),
    .debounce_ticks_i (debounce_q),
    .res_o            (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      out_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, res_q};

endmodule

### sv/mks_checker.sv
module mks_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);

  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |=> !m_axis_tvalid)
    else $error("result pending during reset");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  a_rows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[3:0] == 4'hF || $onehot(m_axis_tdata[3:0])))
    else $error("illegal row drive");

  a_key_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[4] |-> m_axis_tdata[3:0] == 4'hF)
    else $error("scan end without all rows driven");

  a_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[4] ? (m_axis_tdata[9:5] <= 5'd16 ||
      m_axis_tdata[9:5] == 5'd27) : m_axis_tdata[9:5] == 5'd0))
    else $error("bad key code");

endmodule

bind matrix_keypad_scanner_top mks_checker u_mks_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
